### sv/ksat_pkg.sv
// ----------------------------------------------------------------------------
// ksat_pkg: shared types and constants
// Slot count, flush limit, result kinds, opcodes and the structs that pass
// between the slot cells and the table controller.
// ----------------------------------------------------------------------------
package ksat_pkg;

  localparam int SLOTS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int FLUSH_CNT_W = $clog2(MAX_RESULTS);

  localparam logic signed [63:0] S64_HIGHEST = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_LOWEST  = 64'sh8000_0000_0000_0000;

  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  localparam logic [2:0] KIND_ACCEPTED  = 3'd0;
  localparam logic [2:0] KIND_POOL_FULL = 3'd1;
  localparam logic [2:0] KIND_AGGREGATE = 3'd2;
  localparam logic [2:0] KIND_PASSTHRU  = 3'd3;
  localparam logic [2:0] KIND_EMPTY     = 3'd4;

  // commands from the controller to every cell
  typedef struct packed {
    logic               match_en;
    logic               upd_en;
    logic               claim;
    logic               flush_clr;
    logic [63:0]        key;
    logic signed [63:0] value;
  } cell_ctrl_t;

  // priority signals rippling from cell to cell
  typedef struct packed {
    logic free_seen;
    logic idle_seen;
    logic fl_seen;
  } chain_t;

  typedef struct packed {
    logic hit;
    logic first_free;
    logic first_idle;
    logic pick;
    logic more;
  } cell_stat_t;

  typedef struct packed {
    logic [63:0]        key;
    logic [31:0]        count;
    logic signed [63:0] sum;
    logic signed [63:0] min;
    logic signed [63:0] max;
    logic               ovf;
  } slot_rec_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [63:0]        out_key;
    logic [31:0]        sample_count;
    logic signed [63:0] total;
    logic signed [63:0] smallest;
    logic signed [63:0] largest;
    logic               overflowed;
    logic [63:0]        sequence_res;
    logic [63:0]        stamp_out;
    logic               last;
  } out_t;

endpackage

### sv/ksat_if.sv
// ----------------------------------------------------------------------------
// ksat interfaces
// Valid/ready channels for requests, results and the configuration write.
// ----------------------------------------------------------------------------
interface ksat_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [63:0]        series_key;
  logic signed [63:0] sample_value;
  logic [63:0]        time_stamp;

  modport source (output valid, output opcode, output series_key,
                  output sample_value, output time_stamp, input ready);
  modport sink   (input valid, input opcode, input series_key,
                  input sample_value, input time_stamp, output ready);
endinterface

interface ksat_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [63:0]        out_key;
  logic [31:0]        sample_count;
  logic signed [63:0] total;
  logic signed [63:0] smallest;
  logic signed [63:0] largest;
  logic               overflowed;
  logic [63:0]        sequence_res;
  logic [63:0]        stamp_out;
  logic               last;

  modport source (output valid, output kind, output out_key, output sample_count,
                  output total, output smallest, output largest, output overflowed,
                  output sequence_res, output stamp_out, output last, input ready);
  modport sink   (input valid, input kind, input out_key, input sample_count,
                  input total, input smallest, input largest, input overflowed,
                  input sequence_res, input stamp_out, input last, output ready);
endinterface

interface ksat_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### sv/ksat_cell.sv
// ----------------------------------------------------------------------------
// ksat_cell: one aggregation slot
// Holds key, count, sum, min, max and overflow of one series, compares its
// key, and takes part in the priority chain for claiming and flushing.
// ----------------------------------------------------------------------------
module ksat_cell (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ksat_pkg::cell_ctrl_t   ctrl,
  input  logic                   sel,
  input  ksat_pkg::chain_t       chain_in,
  output ksat_pkg::chain_t       chain_out,
  output ksat_pkg::cell_stat_t   stat,
  output ksat_pkg::slot_rec_t    rec
);

  logic               active_r, active_nxt;
  logic [63:0]        key_r;
  logic [31:0]        cnt_r;
  logic signed [63:0] sum_r;
  logic signed [63:0] min_r;
  logic signed [63:0] max_r;
  logic               ovf_r;
  logic               hit_r, free_r, idle_r;

  logic               nonempty;
  logic signed [63:0] sum_add;
  logic               ovf_add;

  assign nonempty = active_r && (cnt_r != 32'd0);
  assign sum_add  = sum_r + ctrl.value;
  // same operand signs, result sign differs
  assign ovf_add  = (sum_r[63] == ctrl.value[63]) && (sum_add[63] != ctrl.value[63]);

  assign chain_out.free_seen = chain_in.free_seen | free_r;
  assign chain_out.idle_seen = chain_in.idle_seen | idle_r;
  assign chain_out.fl_seen   = chain_in.fl_seen | nonempty;

  assign stat.hit        = hit_r;
  assign stat.first_free = free_r & ~chain_in.free_seen;
  assign stat.first_idle = idle_r & ~chain_in.idle_seen;
  assign stat.pick       = nonempty & ~chain_in.fl_seen;
  assign stat.more       = nonempty & chain_in.fl_seen;

  // masked so the controller can or the records together
  assign rec.key   = stat.pick ? key_r : 64'd0;
  assign rec.count = stat.pick ? cnt_r : 32'd0;
  assign rec.sum   = stat.pick ? sum_r : 64'sd0;
  assign rec.min   = stat.pick ? min_r : 64'sd0;
  assign rec.max   = stat.pick ? max_r : 64'sd0;
  assign rec.ovf   = stat.pick & ovf_r;

  always_comb begin
    active_nxt = active_r;
    if (ctrl.upd_en && sel && ctrl.claim) begin
      active_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      hit_r    <= 1'b0;
      free_r   <= 1'b0;
      idle_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      if (ctrl.match_en) begin
        hit_r  <= active_r && (key_r == ctrl.key);
        free_r <= ~active_r;
        idle_r <= active_r && (cnt_r == 32'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd_en && sel) begin
      if (ctrl.claim) begin
        // fresh slot: clear then add one sample
        key_r <= ctrl.key;
        cnt_r <= 32'd1;
        sum_r <= ctrl.value;
        min_r <= ctrl.value;
        max_r <= ctrl.value;
        ovf_r <= 1'b0;
      end else begin
        if (cnt_r != 32'hFFFF_FFFF) begin
          cnt_r <= cnt_r + 32'd1;
        end
        sum_r <= sum_add;
        ovf_r <= ovf_r | ovf_add;
        if (ctrl.value < min_r) begin
          min_r <= ctrl.value;
        end
        if (ctrl.value > max_r) begin
          max_r <= ctrl.value;
        end
      end
    end else if (ctrl.flush_clr && stat.pick) begin
      cnt_r <= 32'd0;
      sum_r <= 64'sd0;
      min_r <= ksat_pkg::S64_HIGHEST;
      max_r <= ksat_pkg::S64_LOWEST;
      ovf_r <= 1'b0;
    end
  end

endmodule

### sv/keyed_stats_aggregation_table_unit.sv
// ----------------------------------------------------------------------------
// keyed_stats_aggregation_table_unit: keyed count/sum/min/max table
// Controller, output register and the row of slot cells.
// ----------------------------------------------------------------------------
// A report with aggregation on goes through the states IDLE to take the
// request, MATCH for every cell to register its key compare, SEL for the
// claim priority chain across the cells, and UPD for the selected cell to
// update while the single result is loaded. A passthrough report goes through
// IDLE and PASS. A flush emits at least one result, since in each cycle in
// which the output register is free the flush chain picks the first non-empty
// slot, loads its record into the output register and clears it. UPD, PASS
// and FLUSH wait while the output register is still held by the sink.
// A new request is taken only when the previous one is finished.
module keyed_stats_aggregation_table_unit (
  input  logic          clk,
  input  logic          rst_n,
  ksat_in_if.sink       in_if,
  ksat_out_if.source    out_if,
  ksat_cfg_if.sink      cfg_if
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MATCH = 3'd1;
  localparam logic [2:0] ST_SEL   = 3'd2;
  localparam logic [2:0] ST_UPD   = 3'd3;
  localparam logic [2:0] ST_PASS  = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [2:0]                    state_r, state_nxt;
  logic                          agg_r;
  logic [63:0]                   seq_r, seq_nxt;
  logic [ksat_pkg::FLUSH_CNT_W-1:0] fcnt_r, fcnt_nxt;

  logic                          req_op_r;
  logic [63:0]                   req_key_r;
  logic signed [63:0]            req_val_r;
  logic [63:0]                   req_stamp_r;

  logic [ksat_pkg::SLOTS-1:0]    sel_r, sel_nxt;
  logic                          claim_r, claim_nxt;
  logic                          full_r, full_nxt;

  logic                          out_valid_r, out_valid_nxt;
  ksat_pkg::out_t                out_r, out_nxt;
  logic                          out_free;
  logic                          in_take;

  ksat_pkg::cell_ctrl_t          ctrl;
  ksat_pkg::chain_t              chain [ksat_pkg::SLOTS+1];
  ksat_pkg::cell_stat_t          stat  [ksat_pkg::SLOTS];
  ksat_pkg::slot_rec_t           recs  [ksat_pkg::SLOTS];

  logic [ksat_pkg::SLOTS-1:0]    hit_vec, free_vec, idle_vec, pick_vec, more_vec;
  logic [$bits(ksat_pkg::slot_rec_t)-1:0] rec_bits;
  ksat_pkg::slot_rec_t           rec_pick;
  logic                          flush_last;

  assign out_free     = ~out_valid_r | out_if.ready;
  assign in_if.ready  = (state_r == ST_IDLE);
  assign in_take      = in_if.valid & in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign chain[0] = '0;

  for (genvar i = 0; i < ksat_pkg::SLOTS; i++) begin : g_cell
    ksat_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .sel       (sel_r[i]),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .stat      (stat[i]),
      .rec       (recs[i])
    );
    assign hit_vec[i]  = stat[i].hit;
    assign free_vec[i] = stat[i].first_free;
    assign idle_vec[i] = stat[i].first_idle;
    assign pick_vec[i] = stat[i].pick;
    assign more_vec[i] = stat[i].more;
  end

  always_comb begin
    rec_bits = '0;
    for (int i = 0; i < ksat_pkg::SLOTS; i++) begin
      rec_bits = rec_bits | recs[i];
    end
  end
  assign rec_pick = ksat_pkg::slot_rec_t'(rec_bits);

  assign flush_last = ~(|more_vec) ||
                      (fcnt_r == ksat_pkg::FLUSH_CNT_W'(ksat_pkg::MAX_RESULTS - 1));

  always_comb begin
    state_nxt     = state_r;
    seq_nxt       = seq_r;
    fcnt_nxt      = fcnt_r;
    sel_nxt       = sel_r;
    claim_nxt     = claim_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r & ~out_if.ready;
    out_nxt       = out_r;

    ctrl.match_en  = (state_r == ST_MATCH);
    ctrl.upd_en    = 1'b0;
    ctrl.claim     = claim_r;
    ctrl.flush_clr = 1'b0;
    ctrl.key       = req_key_r;
    ctrl.value     = req_val_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          fcnt_nxt = '0;
          if (in_if.opcode == ksat_pkg::OP_FLUSH) begin
            state_nxt = ST_FLUSH;
          end else if (!agg_r) begin
            state_nxt = ST_PASS;
          end else begin
            state_nxt = ST_MATCH;
          end
        end
      end
      ST_MATCH: begin
        state_nxt = ST_SEL;
      end
      ST_SEL: begin
        // an existing key wins, then the first free slot, then the first idle
        claim_nxt = ~(|hit_vec);
        full_nxt  = 1'b0;
        if (|hit_vec) begin
          sel_nxt = hit_vec;
        end else if (|free_vec) begin
          sel_nxt = free_vec;
        end else if (|idle_vec) begin
          sel_nxt = idle_vec;
        end else begin
          sel_nxt  = '0;
          full_nxt = 1'b1;
        end
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          ctrl.upd_en   = ~full_r;
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          out_nxt.kind  = full_r ? ksat_pkg::KIND_POOL_FULL : ksat_pkg::KIND_ACCEPTED;
          out_nxt.out_key   = req_key_r;
          out_nxt.stamp_out = req_stamp_r;
          out_nxt.last      = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      ST_PASS: begin
        if (out_free) begin
          out_valid_nxt        = 1'b1;
          out_nxt.kind         = ksat_pkg::KIND_PASSTHRU;
          out_nxt.out_key      = req_key_r;
          out_nxt.sample_count = 32'd1;
          out_nxt.total        = req_val_r;
          out_nxt.smallest     = req_val_r;
          out_nxt.largest      = req_val_r;
          out_nxt.overflowed   = 1'b0;
          out_nxt.sequence_res = seq_r;
          out_nxt.stamp_out    = req_stamp_r;
          out_nxt.last         = 1'b1;
          seq_nxt              = seq_r + 64'd1;
          state_nxt            = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_nxt.stamp_out = req_stamp_r;
          if (|pick_vec) begin
            ctrl.flush_clr       = 1'b1;
            out_nxt.kind         = ksat_pkg::KIND_AGGREGATE;
            out_nxt.out_key      = rec_pick.key;
            out_nxt.sample_count = rec_pick.count;
            out_nxt.total        = rec_pick.sum;
            out_nxt.smallest     = rec_pick.min;
            out_nxt.largest      = rec_pick.max;
            out_nxt.overflowed   = rec_pick.ovf;
            out_nxt.sequence_res = seq_r;
            out_nxt.last         = flush_last;
            seq_nxt              = seq_r + 64'd1;
            fcnt_nxt             = fcnt_r + ksat_pkg::FLUSH_CNT_W'(1);
            if (flush_last) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            out_nxt.kind         = ksat_pkg::KIND_EMPTY;
            out_nxt.out_key      = '0;
            out_nxt.sample_count = '0;
            out_nxt.total        = '0;
            out_nxt.smallest     = '0;
            out_nxt.largest      = '0;
            out_nxt.overflowed   = 1'b0;
            out_nxt.sequence_res = '0;
            out_nxt.last         = 1'b1;
            state_nxt            = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      agg_r       <= 1'b1;
      seq_r       <= 64'd0;
      fcnt_r      <= '0;
      out_valid_r <= 1'b0;
      sel_r       <= '0;
      claim_r     <= 1'b0;
      full_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      seq_r       <= seq_nxt;
      fcnt_r      <= fcnt_nxt;
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
      claim_r     <= claim_nxt;
      full_r      <= full_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        agg_r <= cfg_if.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (in_take) begin
      req_op_r    <= in_if.opcode;
      req_key_r   <= in_if.series_key;
      req_val_r   <= in_if.sample_value;
      req_stamp_r <= in_if.time_stamp;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.kind         = out_r.kind;
  assign out_if.out_key      = out_r.out_key;
  assign out_if.sample_count = out_r.sample_count;
  assign out_if.total        = out_r.total;
  assign out_if.smallest     = out_r.smallest;
  assign out_if.largest      = out_r.largest;
  assign out_if.overflowed   = out_r.overflowed;
  assign out_if.sequence_res = out_r.sequence_res;
  assign out_if.stamp_out    = out_r.stamp_out;
  assign out_if.last         = out_r.last;

  // keys held in active slots are unique
  a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEL) |-> $onehot0(hit_vec))
    else $error("more than one slot holds the request key");

  // at most one slot is updated by a report
  a_single_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> $onehot0(sel_r))
    else $error("more than one slot selected for update");

  // pool full never touches a slot
  a_full_nosel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && full_r) |-> (sel_r == '0))
    else $error("slot selected while pool full");

  // a flush request only comes through the flush path
  a_flush_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MATCH || state_r == ST_PASS) |-> (req_op_r == ksat_pkg::OP_REPORT))
    else $error("flush request in report path");

endmodule
